// ===== rtl/plst_pkg.sv =====
// ----------------------------------------------------------------------------
// plst_pkg
// Shared types and codes for the positional list store: request and result
// transaction layouts, request and status codes, and the row command.
// ----------------------------------------------------------------------------
package plst_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Request codes carried in req_type.
    localparam logic [2:0] REQ_INS_FRONT = 3'd0;
    localparam logic [2:0] REQ_INS_BACK  = 3'd1;
    localparam logic [2:0] REQ_DEL_FRONT = 3'd2;
    localparam logic [2:0] REQ_DEL_BACK  = 3'd3;
    localparam logic [2:0] REQ_INS_AT    = 3'd4;
    localparam logic [2:0] REQ_DEL_AT    = 3'd5;
    localparam logic [2:0] REQ_READ_OUT  = 3'd6;

    // Status codes carried in status.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] value;
        logic [4:0]  position;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  entries;
        logic [31:0] element;
        logic        element_valid;
        logic        last;
    } out_item_t;

    // Operation applied to the register row.
    typedef enum logic [2:0] {
        ROW_HOLD,
        ROW_INS_FRONT,
        ROW_INS_BACK,
        ROW_INS_AT,
        ROW_DEL_FRONT,
        ROW_DEL_BACK,
        ROW_DEL_AT,
        ROW_ROTATE
    } row_op_t;

    typedef struct packed {
        row_op_t    op;
        logic [4:0] position;
    } row_cmd_t;

endpackage

// ===== rtl/plst_row.sv =====
// ----------------------------------------------------------------------------
// plst_row
// Register row holding the list entries, front at index zero, with the fill
// count. Inserts, deletes and the read-out rotation are parallel shifts.
// ----------------------------------------------------------------------------
module plst_row #(
    parameter int CAPACITY   = plst_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = plst_pkg::DATA_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  plst_pkg::row_cmd_t               cmd,
    input  logic [31:0]                      value,
    output logic [$clog2(CAPACITY+1)-1:0]    fill,
    output logic [DATA_WIDTH-1:0]            head
);
    import plst_pkg::*;

    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int CW     = ((FILL_W > 5) ? FILL_W : 5) + 1;

    logic [DATA_WIDTH-1:0] slot_reg  [CAPACITY];
    logic [DATA_WIDTH-1:0] slot_next [CAPACITY];
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;
    logic [DATA_WIDTH-1:0] din;
    logic [CW-1:0]         fill_ext;
    logic [CW-1:0]         ins_idx;
    logic [CW-1:0]         del_idx;

    assign din      = DATA_WIDTH'(value);
    assign fill_ext = CW'(fill_reg);

    always_comb begin
        ins_idx = '0;
        del_idx = '0;
        unique case (cmd.op)
            ROW_INS_BACK: ins_idx = fill_ext;
            ROW_INS_AT:   ins_idx = CW'(cmd.position) - CW'(1);
            ROW_DEL_BACK: del_idx = fill_ext - CW'(1);
            ROW_DEL_AT:   del_idx = CW'(cmd.position) - CW'(1);
            default: begin
            end
        endcase
    end

    always_comb begin
        slot_next = slot_reg;
        fill_next = fill_reg;
        unique case (cmd.op)
            ROW_INS_FRONT, ROW_INS_BACK, ROW_INS_AT: begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (CW'(i) == ins_idx) begin
                        slot_next[i] = din;
                    end else if (i > 0) begin
                        if (CW'(i) > ins_idx && CW'(i) <= fill_ext) begin
                            slot_next[i] = slot_reg[i-1];
                        end
                    end
                end
                fill_next = fill_reg + FILL_W'(1);
            end
            ROW_DEL_FRONT, ROW_DEL_BACK, ROW_DEL_AT: begin
                for (int i = 0; i < CAPACITY - 1; i++) begin
                    if (CW'(i) >= del_idx && CW'(i) + CW'(1) < fill_ext) begin
                        slot_next[i] = slot_reg[i+1];
                    end
                end
                fill_next = fill_reg - FILL_W'(1);
            end
            ROW_ROTATE: begin
                // The front entry moves to the back of the occupied part.
                for (int i = 0; i < CAPACITY; i++) begin
                    if (CW'(i) + CW'(1) == fill_ext) begin
                        slot_next[i] = slot_reg[0];
                    end else if (i < CAPACITY - 1) begin
                        if (CW'(i) + CW'(1) < fill_ext) begin
                            slot_next[i] = slot_reg[i+1];
                        end
                    end
                end
            end
            ROW_HOLD: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    assign fill = fill_reg;
    assign head = slot_reg[0];

endmodule

// ===== rtl/plst_ctrl.sv =====
// ----------------------------------------------------------------------------
// plst_ctrl
// Request register, request decode with range checks, read-out sequencing
// and the result register.
// ----------------------------------------------------------------------------
module plst_ctrl #(
    parameter int CAPACITY   = plst_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = plst_pkg::DATA_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  plst_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output plst_pkg::out_item_t              m_data,
    output plst_pkg::row_cmd_t               cmd,
    output logic [31:0]                      value,
    input  logic [$clog2(CAPACITY+1)-1:0]    fill,
    input  logic [DATA_WIDTH-1:0]            head
);
    import plst_pkg::*;

    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int CW     = ((FILL_W > 5) ? FILL_W : 5) + 1;

    logic              req_valid_reg;
    logic              req_valid_next;
    in_item_t          req_reg;
    logic [FILL_W-1:0] cnt_reg;
    logic [FILL_W-1:0] cnt_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    out_item_t         m_data_reg;
    out_item_t         m_data_next;

    logic              out_free;
    logic              step;
    logic              done;
    logic              is_full;
    logic              is_empty;
    logic [CW-1:0]     pos_ext;
    logic [CW-1:0]     fill_ext;
    row_op_t           op;
    logic [1:0]        status;
    logic [FILL_W-1:0] entries_after;
    logic              elem_valid;
    logic              last;

    assign out_free = !m_valid_reg || m_ready;
    assign step     = req_valid_reg && out_free;
    assign done     = step && last;
    assign s_ready  = !req_valid_reg || done;

    assign is_full  = (fill == FILL_W'(CAPACITY));
    assign is_empty = (fill == '0);
    assign pos_ext  = CW'(req_reg.position);
    assign fill_ext = CW'(fill);

    always_comb begin
        op         = ROW_HOLD;
        status     = ST_DONE;
        elem_valid = 1'b0;
        last       = 1'b1;
        unique case (req_reg.req_type)
            REQ_INS_FRONT: begin
                if (is_full) status = ST_FULL;
                else         op     = ROW_INS_FRONT;
            end
            REQ_INS_BACK: begin
                if (is_full) status = ST_FULL;
                else         op     = ROW_INS_BACK;
            end
            REQ_DEL_FRONT: begin
                if (is_empty) status = ST_EMPTY;
                else          op     = ROW_DEL_FRONT;
            end
            REQ_DEL_BACK: begin
                if (is_empty) status = ST_EMPTY;
                else          op     = ROW_DEL_BACK;
            end
            REQ_INS_AT: begin
                if (pos_ext == '0 || pos_ext > fill_ext + CW'(1)) status = ST_RANGE;
                else if (is_full)                                 status = ST_FULL;
                else                                              op     = ROW_INS_AT;
            end
            REQ_DEL_AT: begin
                if (is_empty)                                 status = ST_EMPTY;
                else if (pos_ext == '0 || pos_ext > fill_ext) status = ST_RANGE;
                else                                          op     = ROW_DEL_AT;
            end
            REQ_READ_OUT: begin
                if (!is_empty) begin
                    op         = ROW_ROTATE;
                    elem_valid = 1'b1;
                    last       = (cnt_reg == fill - FILL_W'(1));
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        unique case (op)
            ROW_INS_FRONT, ROW_INS_BACK, ROW_INS_AT: entries_after = fill + FILL_W'(1);
            ROW_DEL_FRONT, ROW_DEL_BACK, ROW_DEL_AT: entries_after = fill - FILL_W'(1);
            default:                                 entries_after = fill;
        endcase
    end

    assign cmd.op       = step ? op : ROW_HOLD;
    assign cmd.position = req_reg.position;
    assign value        = req_reg.value;

    always_comb begin
        m_data_next.status        = status;
        m_data_next.entries       = 5'(entries_after);
        m_data_next.element       = elem_valid ? 32'(head) : 32'd0;
        m_data_next.element_valid = elem_valid;
        m_data_next.last          = last;
    end

    always_comb begin
        req_valid_next = req_valid_reg;
        if (s_valid && s_ready) req_valid_next = 1'b1;
        else if (done)          req_valid_next = 1'b0;

        cnt_next = cnt_reg;
        if (step) cnt_next = last ? '0 : cnt_reg + FILL_W'(1);

        m_valid_next = m_valid_reg;
        if (step)         m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            req_valid_reg <= req_valid_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) req_reg <= s_data;
        if (step)               m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/positional_list_store_core.sv =====
// ----------------------------------------------------------------------------
// positional_list_store_core
// Bounded ordered list with front, back and positional insert and delete,
// and a full read-out of the list in order.
// ----------------------------------------------------------------------------
// Usage: requests arrive as transactions on the s_ channel (s_valid, s_ready,
// s_data) and results leave as transactions on the m_ channel (m_valid,
// m_ready, m_data). Every insert, delete or unused request code produces one
// result transaction with last set. A read-out produces one transaction per
// entry, front first, with last on the final one; an empty list gives a
// single transaction with element_valid clear.
// Timing: a request is taken into the request register, and its first result
// is registered into the result register once that one is free. Inserts and
// deletes sustain one request per cycle while m_ready is high, as each is a
// single parallel shift of the entry row. A read-out holds the block for one
// result per entry: the row rotates one place per result, emitting the front.
// Reset: aresetn is synchronous and active low; it empties the list and drops
// any pending request or result. Entry contents are not cleared.
// Stalls: when m_ready is low the result register holds its transaction; one
// further request is still taken into the request register, after which
// s_ready stays low until the result register drains.
// ----------------------------------------------------------------------------
module positional_list_store_core #(
    parameter int CAPACITY   = plst_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = plst_pkg::DATA_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  plst_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output plst_pkg::out_item_t m_data
);
    import plst_pkg::*;

    localparam int FILL_W = $clog2(CAPACITY + 1);

    // Command from the sequencer to the entry row, applied at the next edge.
    row_cmd_t              cmd;
    logic [31:0]           value;
    // Current entry count and the front entry, as seen by the sequencer.
    logic [FILL_W-1:0]     fill;
    logic [DATA_WIDTH-1:0] head;

    plst_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .value   (value),
        .fill    (fill),
        .head    (head)
    );

    plst_row #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_row (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .value   (value),
        .fill    (fill),
        .head    (head)
    );

endmodule
